// File: rtl/uzm_pkg.sv
// Shared constants, phase codes and register indexes for the range zone monitor.
`default_nettype none

package uzm_pkg;

    // Field and register widths
    localparam int TickW    = 20;
    localparam int WidthW   = 16;
    localparam int DistW    = 17;
    localparam int ProdW    = 27;
    localparam int ScaledW  = 19;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 20;
    localparam int InDataW  = 8;
    localparam int OutDataW = 32;

    // Echo width to cm, Q8: 0.01715 * 65536 rounded, product shifted right by 8
    localparam logic [10:0] ScaleQ16 = 11'd1124;
    localparam int ScaleShift = 8;

    // Measurement phases
    localparam logic [2:0] PhGap      = 3'd0;
    localparam logic [2:0] PhTrigLow  = 3'd1;
    localparam logic [2:0] PhTrigHigh = 3'd2;
    localparam logic [2:0] PhWaitRise = 3'd3;
    localparam logic [2:0] PhMeasure  = 3'd4;

    // Zone codes
    localparam logic [1:0] ZoneError  = 2'd0;
    localparam logic [1:0] ZoneFar    = 2'd1;
    localparam logic [1:0] ZoneMedium = 2'd2;
    localparam logic [1:0] ZoneClose  = 2'd3;

    // Configuration register indexes
    localparam logic [CfgAddrW-1:0] RegEnable      = 3'd0;
    localparam logic [CfgAddrW-1:0] RegTrigLow     = 3'd1;
    localparam logic [CfgAddrW-1:0] RegTrigHigh    = 3'd2;
    localparam logic [CfgAddrW-1:0] RegEchoTimeout = 3'd3;
    localparam logic [CfgAddrW-1:0] RegThreshLow   = 3'd4;
    localparam logic [CfgAddrW-1:0] RegThreshHigh  = 3'd5;
    localparam logic [CfgAddrW-1:0] RegMaxDistance = 3'd6;
    localparam logic [CfgAddrW-1:0] RegGapTicks    = 3'd7;

    // Output tdata bit positions
    localparam int OutTrigBit   = 0;
    localparam int OutFarBit    = 1;
    localparam int OutMedBit    = 2;
    localparam int OutCloseBit  = 3;
    localparam int OutDistLsb   = 4;
    localparam int OutValidBit  = 21;
    localparam int OutZoneLsb   = 22;
    localparam int OutDoneBit   = 24;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_range_zone_monitor.sv
// Ultrasonic echo-pulse ranging with three-zone indicator lights.
//
// Usage:
//   The slave stream carries one transfer per microsecond tick; bit 0 of
//   s_tdata is the sampled echo level. Every accepted tick yields exactly one
//   transfer on the master stream with the trigger drive, the three lights,
//   the last valid distance (cm, Q8), the valid flag, the zone code and a
//   one-tick done pulse when a measurement completes.
//   The phase sequencer, the echo width scaling (one 16x11 constant
//   multiply) and the zone compare sit between the state registers and the
//   output register. One tick is taken every cycle unless the output stalls.
//   s_tready follows the output register: a tick is accepted whenever the
//   output register is empty or is being drained, so a stalled receiver
//   holds the pending result and backs up the slave side after one entry.
//   Reset (rst_n low, asynchronous) loads the register defaults, puts the
//   sequencer in the gap phase with a zero count, clears the stored distance,
//   valid flag and zone, and empties the output register.
//   Configuration writes (cfg_we, cfg_addr, cfg_data) take effect at the
//   clock edge on which cfg_we is high; write them while the stream is idle.
`default_nettype none

module ultrasonic_range_zone_monitor
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [uzm_pkg::CfgAddrW-1:0]   cfg_addr,
    input  wire logic [uzm_pkg::CfgDataW-1:0]   cfg_data,
    // tick stream in
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [uzm_pkg::InDataW-1:0]    s_tdata,  // [0] echo_level, rest zero
    // result stream out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] trigger_out, [1] light_far, [2] light_medium, [3] light_close,
    // [20:4] distance_q8, [21] reading_valid, [23:22] zone, [24] reading_done
    output logic [uzm_pkg::OutDataW-1:0]        m_tdata
);

    import uzm_pkg::*;

    // Configuration registers
    logic               enable_reg;
    logic [7:0]         trig_low_reg;
    logic [7:0]         trig_high_reg;
    logic [WidthW-1:0]  timeout_reg;
    logic [DistW-1:0]   thresh_low_reg;
    logic [DistW-1:0]   thresh_high_reg;
    logic [DistW-1:0]   max_dist_reg;
    logic [TickW-1:0]   gap_reg;

    // Measurement state
    logic [2:0]         phase_reg,  phase_next;
    logic [TickW-1:0]   tick_reg,   tick_next;
    logic [WidthW-1:0]  width_reg,  width_next;
    logic [DistW-1:0]   dist_reg,   dist_next;
    logic               valid_reg,  valid_next;
    logic [1:0]         zone_reg,   zone_next;

    // Output register
    logic               out_valid_reg;
    logic [OutDataW-1:0] out_data_reg, out_data_next;

    logic               accept;
    logic               echo;
    logic               trig;
    logic               done;
    logic [TickW:0]     tick_inc;
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] dist_scaled;
    logic               finish;
    logic               timed_out;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign echo     = s_tdata[0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign tick_inc    = {1'b0, tick_reg} + {{TickW{1'b0}}, 1'b1};
    assign prod        = ProdW'(width_reg) * ProdW'(ScaleQ16);
    assign dist_scaled = prod[ProdW-1:ScaleShift];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            trig_low_reg    <= 8'd2;
            trig_high_reg   <= 8'd10;
            timeout_reg     <= 16'd30000;
            thresh_low_reg  <= 17'd5120;
            thresh_high_reg <= 17'd12800;
            max_dist_reg    <= 17'd102400;
            gap_reg         <= 20'd100000;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                RegEnable:      enable_reg      <= cfg_data[0];
                RegTrigLow:     trig_low_reg    <= cfg_data[7:0];
                RegTrigHigh:    trig_high_reg   <= cfg_data[7:0];
                RegEchoTimeout: timeout_reg     <= cfg_data[WidthW-1:0];
                RegThreshLow:   thresh_low_reg  <= cfg_data[DistW-1:0];
                RegThreshHigh:  thresh_high_reg <= cfg_data[DistW-1:0];
                RegMaxDistance: max_dist_reg    <= cfg_data[DistW-1:0];
                RegGapTicks:    gap_reg         <= cfg_data[TickW-1:0];
                default:        ;
            endcase
        end
    end

    // Phase sequencer: one tick of work per accepted transfer
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        width_next = width_reg;
        trig       = 1'b0;
        finish     = 1'b0;
        timed_out  = 1'b0;

        if (!enable_reg)
        begin
            phase_next = PhGap;
            tick_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PhGap:
                begin
                    tick_next = tick_inc[TickW-1:0];
                    if (tick_inc >= {1'b0, gap_reg})
                    begin
                        phase_next = PhTrigLow;
                        tick_next  = '0;
                    end
                end
                PhTrigLow:
                begin
                    tick_next = tick_inc[TickW-1:0];
                    if (tick_inc >= (TickW+1)'(trig_low_reg))
                    begin
                        phase_next = PhTrigHigh;
                        tick_next  = '0;
                    end
                end
                PhTrigHigh:
                begin
                    trig      = 1'b1;
                    tick_next = tick_inc[TickW-1:0];
                    if (tick_inc >= (TickW+1)'(trig_high_reg))
                    begin
                        phase_next = PhWaitRise;
                        tick_next  = '0;
                    end
                end
                PhWaitRise:
                begin
                    if (echo)
                    begin
                        width_next = WidthW'(1);
                        phase_next = PhMeasure;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc[TickW-1:0];
                        if (tick_inc > (TickW+1)'(timeout_reg))
                        begin
                            finish    = 1'b1;
                            timed_out = 1'b1;
                        end
                    end
                end
                PhMeasure:
                begin
                    if (!echo)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc[TickW-1:0];
                        if (tick_inc > (TickW+1)'(timeout_reg))
                        begin
                            finish    = 1'b1;
                            timed_out = 1'b1;
                        end
                        else if (width_reg != {WidthW{1'b1}})
                        begin
                            width_next = width_reg + WidthW'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = PhGap;
                    tick_next  = '0;
                end
            endcase
        end

        if (finish)
        begin
            phase_next = PhGap;
            tick_next  = '0;
        end
    end

    assign done = finish;

    // Classify a finished reading against the range limit and thresholds
    always_comb
    begin
        dist_next  = dist_reg;
        valid_next = valid_reg;
        zone_next  = zone_reg;
        if (finish)
        begin
            if (!timed_out && dist_scaled != '0 &&
                dist_scaled < ScaledW'(max_dist_reg))
            begin
                dist_next  = dist_scaled[DistW-1:0];
                valid_next = 1'b1;
                if (dist_scaled > ScaledW'(thresh_high_reg))
                    zone_next = ZoneFar;
                else if (dist_scaled >= ScaledW'(thresh_low_reg))
                    zone_next = ZoneMedium;
                else
                    zone_next = ZoneClose;
            end
            else
            begin
                valid_next = 1'b0;
                zone_next  = ZoneError;
            end
        end
    end

    // Pack the result transfer
    always_comb
    begin
        out_data_next = '0;
        out_data_next[OutTrigBit]  = trig;
        out_data_next[OutFarBit]   = (zone_next == ZoneFar);
        out_data_next[OutMedBit]   = (zone_next == ZoneMedium);
        out_data_next[OutCloseBit] = (zone_next == ZoneClose);
        out_data_next[OutDistLsb +: DistW] = dist_next;
        out_data_next[OutValidBit] = valid_next;
        out_data_next[OutZoneLsb +: 2]     = zone_next;
        out_data_next[OutDoneBit]  = done;
    end

    // Advance state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PhGap;
            tick_reg  <= '0;
            width_reg <= '0;
            dist_reg  <= '0;
            valid_reg <= 1'b0;
            zone_reg  <= ZoneError;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            width_reg <= width_next;
            dist_reg  <= dist_next;
            valid_reg <= valid_next;
            zone_reg  <= zone_next;
        end
    end

    // Output register: fill on accept, drain on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uzm_checker.sv
// Port-level checker for the range zone monitor and its bind statement.
`default_nettype none

module uzm_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [uzm_pkg::OutDataW-1:0]   m_tdata
);

    import uzm_pkg::*;

    logic [1:0] zone;
    assign zone = m_tdata[OutZoneLsb +: 2];

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Lights follow the zone code
    a_lights: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OutFarBit] == (zone == ZoneFar)) &&
                     (m_tdata[OutMedBit] == (zone == ZoneMedium)) &&
                     (m_tdata[OutCloseBit] == (zone == ZoneClose)))
        else $error("lights disagree with zone");

    // Valid flag set exactly when the zone is not the error code
    a_valid_zone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OutValidBit] == (zone != ZoneError)))
        else $error("valid flag disagrees with zone");

    // A measurement never completes during the trigger pulse
    a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OutTrigBit] && m_tdata[OutDoneBit]))
        else $error("done during trigger pulse");

    // Accept a tick whenever no result is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind ultrasonic_range_zone_monitor uzm_checker u_uzm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
